/* rtl/owik_pkg.sv */
`default_nettype none
package owik_pkg;

  localparam int LANES  = 4;
  localparam int VEL_W  = 16;
  localparam int UW     = 33;   // exact wheel sum, units of 2^-30, signed
  localparam int MAG_W  = 32;   // magnitude of a wheel sum
  localparam int MS_W   = 15;
  localparam int PROD_W = MS_W + MAG_W;
  localparam int NUM_W  = PROD_W + 1;  // 2*n + den
  localparam int DEN_W  = MAG_W + 1;   // 2*den
  localparam int QUO_W  = 15;           // quotient never exceeds max_speed
  localparam int SPD_W  = 16;
  localparam int FRAC_SH = 16;

  localparam logic signed [UW-1:0]    COEF    = 33'sd46341;
  localparam logic signed [VEL_W-1:0] ONE_Q14 = 16'sd16384;
  localparam logic signed [VEL_W-1:0] NEG_ONE = -16'sd16384;
  localparam logic [MAG_W-1:0]        UNIT    = 32'h4000_0000;

  // Lane order: front left, front right, back left, back right.
  localparam logic [LANES-1:0] NEG_X = 4'b0101;
  localparam logic [LANES-1:0] NEG_Y = 4'b1100;

  typedef struct packed {
    logic             vld;
    logic             bad;
    logic [LANES-1:0] neg;
  } owik_tag_t;

endpackage
`default_nettype wire

/* rtl/owik_div.sv */
`default_nettype none
module owik_div (
  input  wire logic                                               clk,
  input  wire logic                                               rst,
  input  wire owik_pkg::owik_tag_t                                tag_in,
  input  wire logic [owik_pkg::LANES-1:0][owik_pkg::NUM_W-1:0]    num,
  input  wire logic [owik_pkg::DEN_W-1:0]                         den,
  output owik_pkg::owik_tag_t                                     tag_out,
  output logic [owik_pkg::LANES-1:0][owik_pkg::QUO_W-1:0]         quo_out
);

  localparam int QW = owik_pkg::QUO_W;
  localparam int NW = owik_pkg::NUM_W;
  localparam int LN = owik_pkg::LANES;

  logic [LN-1:0][NW-1:0]             rem [0:QW-1];
  logic [owik_pkg::DEN_W-1:0]        dd  [0:QW-1];
  logic [LN-1:0][QW-1:0]             quo [0:QW];
  owik_pkg::owik_tag_t               tag [0:QW];

  assign rem[0] = num;
  assign dd[0]  = den;
  assign quo[0] = '0;
  assign tag[0] = tag_in;

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int K = QW - s;
    logic [NW-1:0] dsh;
    logic [LN-1:0] ge;

    assign dsh = NW'(dd[s-1]) << K;

    for (genvar l = 0; l < LN; l++) begin : g_cmp
      assign ge[l] = rem[s-1][l] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[s] <= '0;
      end else begin
        tag[s] <= tag[s-1];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < LN; l++) begin
        quo[s][l] <= quo[s-1][l] | (QW'(ge[l]) << K);
      end
    end

    if (s < QW) begin : g_rem
      always_ff @(posedge clk) begin
        dd[s] <= dd[s-1];
        for (int l = 0; l < LN; l++) begin
          rem[s][l] <= ge[l] ? rem[s-1][l] - dsh : rem[s-1][l];
        end
      end
    end
  end

  assign tag_out = tag[QW];
  assign quo_out = quo[QW];

endmodule
`default_nettype wire

/* rtl/omni_wheel_inverse_kinematics_top.sv */
`default_nettype none
// Four-wheel omni (X layout) inverse kinematics with proportional desaturation.
// A command is taken at any edge with start high and busy low; busy is only
// high during reset, so one command per cycle is sustained. Each command gives
// one result, shown for a single cycle with done high. From the accepting edge,
// six arithmetic stages (range check and coefficient products, wheel sums,
// magnitudes, peak and divisor, max_speed product, dividend) feed a 15-stage
// restoring divider, one quotient bit per stage, then the output register.
// The receiver cannot stall the result. status is 1 when any
// component lies outside -1.0..1.0, and then all speeds are zero. max_speed is
// written through the cfg channel, which is always ready; write it only while
// no command is in flight.
module omni_wheel_inverse_kinematics_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [owik_pkg::VEL_W-1:0]    vel_x,
  input  wire logic signed [owik_pkg::VEL_W-1:0]    vel_y,
  input  wire logic signed [owik_pkg::VEL_W-1:0]    yaw_rate,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [owik_pkg::MS_W-1:0]            cfg_data,
  output logic                                      done,
  output logic                                      status,
  output logic signed [owik_pkg::SPD_W-1:0]         speed_front_left,
  output logic signed [owik_pkg::SPD_W-1:0]         speed_front_right,
  output logic signed [owik_pkg::SPD_W-1:0]         speed_back_left,
  output logic signed [owik_pkg::SPD_W-1:0]         speed_back_right
);

  localparam int LN = owik_pkg::LANES;

  logic [owik_pkg::MS_W-1:0] max_speed;
  logic                      accept;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= '0;
    end else if (cfg_valid && cfg_ready) begin
      max_speed <= cfg_data;
    end
  end

  function automatic logic out_of_range(input logic signed [owik_pkg::VEL_W-1:0] v);
    return (v < owik_pkg::NEG_ONE) || (v > owik_pkg::ONE_Q14);
  endfunction

  // Stage 1: range check and coefficient products.
  logic                               v1, bad1;
  logic signed [owik_pkg::UW-1:0]     a1, b1;
  logic signed [owik_pkg::VEL_W-1:0]  w1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    bad1 <= out_of_range(vel_x) || out_of_range(vel_y) || out_of_range(yaw_rate);
    a1   <= owik_pkg::UW'(vel_x) * owik_pkg::COEF;
    b1   <= owik_pkg::UW'(vel_y) * owik_pkg::COEF;
    w1   <= yaw_rate;
  end

  // Stage 2: exact wheel sums.
  logic                                   v2, bad2;
  logic signed [owik_pkg::UW-1:0]         u2 [LN];
  logic signed [owik_pkg::UW-1:0]         c1;
  logic signed [owik_pkg::UW-1:0]         u_next [LN];

  assign c1 = owik_pkg::UW'(w1) <<< owik_pkg::FRAC_SH;

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      u_next[l] = (owik_pkg::NEG_X[l] ? -a1 : a1) + (owik_pkg::NEG_Y[l] ? -b1 : b1) + c1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    bad2 <= bad1;
    for (int l = 0; l < LN; l++) begin
      u2[l] <= u_next[l];
    end
  end

  // Stage 3: magnitudes and signs.
  owik_pkg::owik_tag_t                tag3;
  logic [owik_pkg::MAG_W-1:0]         mag3 [LN];
  logic [owik_pkg::UW-1:0]            nu2  [LN];
  logic [LN-1:0]                      neg2;

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      nu2[l]  = -u2[l];
      neg2[l] = u2[l][owik_pkg::UW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag3 <= '0;
    end else begin
      tag3 <= '{vld: v2, bad: bad2, neg: neg2};
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LN; l++) begin
      mag3[l] <= neg2[l] ? nu2[l][owik_pkg::MAG_W-1:0] : u2[l][owik_pkg::MAG_W-1:0];
    end
  end

  // Stage 4: peak magnitude and divisor.
  owik_pkg::owik_tag_t                tag4;
  logic [owik_pkg::MAG_W-1:0]         mag4 [LN];
  logic [owik_pkg::MAG_W-1:0]         den4;
  logic [owik_pkg::MAG_W-1:0]         pk01, pk23, peak;

  assign pk01 = (mag3[0] > mag3[1]) ? mag3[0] : mag3[1];
  assign pk23 = (mag3[2] > mag3[3]) ? mag3[2] : mag3[3];
  assign peak = (pk01 > pk23) ? pk01 : pk23;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag4 <= '0;
    end else begin
      tag4 <= tag3;
    end
  end

  // Scale down by the peak only when it exceeds full scale and max_speed is nonzero.
  always_ff @(posedge clk) begin
    den4 <= ((max_speed != '0) && (peak > owik_pkg::UNIT)) ? peak : owik_pkg::UNIT;
    for (int l = 0; l < LN; l++) begin
      mag4[l] <= mag3[l];
    end
  end

  // Stage 5: max_speed products.
  owik_pkg::owik_tag_t                tag5;
  logic [owik_pkg::PROD_W-1:0]        prod5 [LN];
  logic [owik_pkg::MAG_W-1:0]         den5;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag5 <= '0;
    end else begin
      tag5 <= tag4;
    end
  end

  always_ff @(posedge clk) begin
    den5 <= den4;
    for (int l = 0; l < LN; l++) begin
      prod5[l] <= owik_pkg::PROD_W'(max_speed) * owik_pkg::PROD_W'(mag4[l]);
    end
  end

  // Stage 6: dividend 2n + den, divisor 2den, so the quotient rounds half away.
  owik_pkg::owik_tag_t                              tag6;
  logic [LN-1:0][owik_pkg::NUM_W-1:0]               num6;
  logic [owik_pkg::DEN_W-1:0]                       d6;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag6 <= '0;
    end else begin
      tag6 <= tag5;
    end
  end

  always_ff @(posedge clk) begin
    d6 <= {den5, 1'b0};
    for (int l = 0; l < LN; l++) begin
      num6[l] <= {prod5[l], 1'b0} + owik_pkg::NUM_W'(den5);
    end
  end

  owik_pkg::owik_tag_t                        tag_q;
  logic [LN-1:0][owik_pkg::QUO_W-1:0]         quo;

  owik_div u_div (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tag6),
    .num     (num6),
    .den     (d6),
    .tag_out (tag_q),
    .quo_out (quo)
  );

  // Output register: restore sign, drop invalid commands to zero.
  logic signed [owik_pkg::SPD_W-1:0] spd [LN];

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      if (tag_q.bad) begin
        spd[l] = '0;
      end else if (tag_q.neg[l]) begin
        spd[l] = -owik_pkg::SPD_W'(quo[l]);
      end else begin
        spd[l] = owik_pkg::SPD_W'(quo[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag_q.vld;
    end
  end

  always_ff @(posedge clk) begin
    status            <= tag_q.bad;
    speed_front_left  <= spd[0];
    speed_front_right <= spd[1];
    speed_back_left   <= spd[2];
    speed_back_right  <= spd[3];
  end

endmodule
`default_nettype wire
